FILE: rtl/pfa_pkg.sv
`timescale 1ns / 1ps
package pfa_pkg;

  localparam int unsigned W = 62;

  localparam logic [W-1:0] PRIME = 62'd3781996138433268199;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_INV = 2'd3;

  // shared unit operations
  localparam logic [1:0] UOP_ADD  = 2'd0;
  localparam logic [1:0] UOP_SUB  = 2'd1;
  localparam logic [1:0] UOP_HALF = 2'd2;

  typedef struct packed {
    logic [1:0]   opcode;
    logic [W-1:0] operand_a;
    logic [W-1:0] operand_b;
  } req_t;

  typedef struct packed {
    logic [W-1:0] result;
    logic         zero_inverse;
  } rsp_t;

endpackage

FILE: rtl/prime_field_alu.sv
`timescale 1ns / 1ps
// Modular ALU over the prime field of order 3781996138433268199.
// Command channel: present req (opcode, operand_a, operand_b) with start high;
// the beat is taken at a rising edge where start is high and busy is low.
// busy stays high until the result is delivered, so one beat is in work at
// a time. Operands at or above the modulus are folded once on entry.
// Result channel: rsp (result, zero_inverse) is valid for exactly one cycle
// while done is high; the receiver cannot stall it and must take it then.
// busy drops in the same cycle that done is high, so the next beat may be
// taken while the result is shown.
// Sequence after the accepting edge: fold a, fold b, then by opcode:
//   add, subtract: one pass through the shared unit; multiply: 62
//   double-and-add steps, two passes each through the shared modular adder;
//   inverse: data dependent, halving steps, then subtraction rounds;
//   inverse of zero: no further work, result zero, zero_inverse set.
// The modular add, subtract and halve steps all share one add/subtract/halve
// unit. Reset returns the sequencer to idle and drops done.
module prime_field_alu
  import pfa_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t req,
  output logic done,
  output rsp_t rsp
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_FOLD_A   = 4'd1;
  localparam logic [3:0] S_FOLD_B   = 4'd2;
  localparam logic [3:0] S_ADDSUB   = 4'd3;
  localparam logic [3:0] S_MUL_DBL  = 4'd4;
  localparam logic [3:0] S_MUL_ADD  = 4'd5;
  localparam logic [3:0] S_INV_NORM = 4'd6;
  localparam logic [3:0] S_INV_SWAP = 4'd7;
  localparam logic [3:0] S_INV_TEST = 4'd8;
  localparam logic [3:0] S_INV_D    = 4'd9;
  localparam logic [3:0] S_INV_CD   = 4'd10;
  localparam logic [3:0] S_INV_HALF = 4'd11;

  localparam logic [5:0] LAST_BIT = 6'(W - 1);

  logic [3:0]   state;
  logic [1:0]   opc;
  logic [W-1:0] a;
  logic [W-1:0] b;
  logic [W-1:0] acc;
  logic [5:0]   cnt;
  logic [W-1:0] hi;
  logic [W-1:0] lo;
  logic [W-1:0] chi;
  logic [W-1:0] clo;
  logic [W-1:0] d;
  logic [W-1:0] cd;

  logic [1:0]   uop;
  logic [W-1:0] ux;
  logic [W-1:0] uy;
  logic [W-1:0] ur;

  pfa_modunit u_unit (
    .uop (uop),
    .x   (ux),
    .y   (uy),
    .r   (ur)
  );

  assign busy = (state != S_IDLE);

  always_comb begin
    uop = UOP_SUB;
    ux  = a;
    uy  = PRIME;
    case (state)
      S_FOLD_A: begin
        uop = UOP_SUB; ux = a; uy = PRIME;
      end
      S_FOLD_B: begin
        uop = UOP_SUB; ux = b; uy = PRIME;
      end
      S_ADDSUB: begin
        uop = (opc == OP_ADD) ? UOP_ADD : UOP_SUB; ux = a; uy = b;
      end
      S_MUL_DBL: begin
        uop = UOP_ADD; ux = acc; uy = acc;
      end
      S_MUL_ADD: begin
        uop = UOP_ADD; ux = acc; uy = a;
      end
      S_INV_NORM: begin
        uop = UOP_HALF; ux = chi; uy = chi;
      end
      S_INV_D: begin
        uop = UOP_SUB; ux = hi; uy = lo;
      end
      S_INV_CD: begin
        uop = UOP_SUB; ux = chi; uy = clo;
      end
      S_INV_HALF: begin
        uop = UOP_HALF; ux = cd; uy = cd;
      end
      default: begin
        uop = UOP_SUB; ux = a; uy = PRIME;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            opc   <= req.opcode;
            a     <= req.operand_a;
            b     <= req.operand_b;
            state <= S_FOLD_A;
          end
        end
        S_FOLD_A: begin
          a     <= ur;
          state <= S_FOLD_B;
        end
        S_FOLD_B: begin
          b   <= ur;
          acc <= '0;
          cnt <= LAST_BIT;
          hi  <= a;
          lo  <= PRIME;
          chi <= {{(W-1){1'b0}}, 1'b1};
          clo <= '0;
          case (opc)
            OP_ADD, OP_SUB: state <= S_ADDSUB;
            OP_MUL:         state <= S_MUL_DBL;
            default: begin
              if (a == '0) begin
                rsp.result       <= '0;
                rsp.zero_inverse <= 1'b1;
                done             <= 1'b1;
                state            <= S_IDLE;
              end else begin
                state <= S_INV_NORM;
              end
            end
          endcase
        end
        S_ADDSUB: begin
          rsp.result       <= ur;
          rsp.zero_inverse <= 1'b0;
          done             <= 1'b1;
          state            <= S_IDLE;
        end
        S_MUL_DBL: begin
          acc   <= ur;
          state <= S_MUL_ADD;
        end
        S_MUL_ADD: begin
          if (b[cnt]) begin
            acc <= ur;
          end
          if (cnt == '0) begin
            rsp.result       <= b[cnt] ? ur : acc;
            rsp.zero_inverse <= 1'b0;
            done             <= 1'b1;
            state            <= S_IDLE;
          end else begin
            cnt   <= cnt - 6'd1;
            state <= S_MUL_DBL;
          end
        end
        S_INV_NORM: begin
          // strip factors of two from the operand, halving its cofactor
          if (!hi[0]) begin
            hi  <= hi >> 1;
            chi <= ur;
          end else begin
            state <= S_INV_SWAP;
          end
        end
        S_INV_SWAP: begin
          if (lo > hi) begin
            hi  <= lo;
            lo  <= hi;
            chi <= clo;
            clo <= chi;
          end
          state <= S_INV_TEST;
        end
        S_INV_TEST: begin
          if (lo != '0 && lo != hi) begin
            state <= S_INV_D;
          end else begin
            rsp.result       <= chi;
            rsp.zero_inverse <= 1'b0;
            done             <= 1'b1;
            state            <= S_IDLE;
          end
        end
        S_INV_D: begin
          d     <= ur;
          state <= S_INV_CD;
        end
        S_INV_CD: begin
          cd    <= ur;
          state <= S_INV_HALF;
        end
        S_INV_HALF: begin
          if (d != '0 && !d[0]) begin
            d  <= d >> 1;
            cd <= ur;
          end else begin
            // keep the smaller value in lo
            if (d < lo) begin
              hi  <= lo;
              chi <= clo;
              lo  <= d;
              clo <= cd;
            end else begin
              hi  <= d;
              chi <= cd;
            end
            state <= S_INV_TEST;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/pfa_modunit.sv
`timescale 1ns / 1ps
module pfa_modunit
  import pfa_pkg::*;
(
  input  logic [1:0]   uop,
  input  logic [W-1:0] x,
  input  logic [W-1:0] y,
  output logic [W-1:0] r
);

  logic [W:0]   sum;
  logic [W+1:0] sum_red;
  logic [W+1:0] diff;
  logic [W-1:0] diff_fix;
  logic [W:0]   half_sum;

  always_comb begin
    sum      = {1'b0, x} + {1'b0, y};
    sum_red  = {1'b0, sum} - {2'b00, PRIME};
    diff     = {2'b00, x} - {2'b00, y};
    // wrap past zero: adding the modulus mod 2^W lands in range
    diff_fix = diff[W-1:0] + PRIME;
    half_sum = {1'b0, x} + (x[0] ? {1'b0, PRIME} : {(W+1){1'b0}});
    case (uop)
      UOP_ADD:  r = sum_red[W+1] ? sum[W-1:0] : sum_red[W-1:0];
      UOP_SUB:  r = diff[W+1] ? diff_fix : diff[W-1:0];
      UOP_HALF: r = half_sum[W:1];
      default:  r = x;
    endcase
  end

endmodule

FILE: tb/sv/pfa_result_checker.sv
`timescale 1ns / 1ps
module pfa_result_checker
  import pfa_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic busy,
  input  req_t req,
  input  logic done,
  input  rsp_t rsp,
  output int   mismatches,
  output int   outstanding
);

  rsp_t expected_rsp_q[$];
  int   fail_cnt = 0;
  int   pending_cnt = 0;

  assign mismatches  = fail_cnt;
  assign outstanding = pending_cnt;

  // inputs at or above the modulus lose one copy of it
  function automatic logic [W-1:0] fold_once(input logic [W-1:0] x);
    return (x >= PRIME) ? x - PRIME : x;
  endfunction

  function automatic logic [W-1:0] field_add(input logic [W-1:0] x, input logic [W-1:0] y);
    logic [W:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, PRIME}) s = s - {1'b0, PRIME};
    return s[W-1:0];
  endfunction

  function automatic logic [W-1:0] field_sub(input logic [W-1:0] x, input logic [W-1:0] y);
    logic [W:0] s;
    if (x >= y) s = {1'b0, x} - {1'b0, y};
    else s = {1'b0, x} + {1'b0, PRIME} - {1'b0, y};
    return s[W-1:0];
  endfunction

  function automatic logic [W-1:0] field_mul(input logic [W-1:0] x, input logic [W-1:0] y);
    logic [2*W-1:0] wx, wy, prod, rem;
    wx   = {{W{1'b0}}, x};
    wy   = {{W{1'b0}}, y};
    prod = wx * wy;
    rem  = prod % {{W{1'b0}}, PRIME};
    return rem[W-1:0];
  endfunction

  // division-based extended Euclid; x is nonzero and reduced
  function automatic logic [W-1:0] field_inv(input logic [W-1:0] x);
    longint r_prev, r_cur, r_next, t_prev, t_cur, t_next, q;
    r_prev = longint'({2'b00, PRIME});
    r_cur  = longint'({2'b00, x});
    t_prev = 0;
    t_cur  = 1;
    while (r_cur != 0) begin
      q      = r_prev / r_cur;
      r_next = r_prev - q * r_cur;
      t_next = t_prev - q * t_cur;
      r_prev = r_cur;
      r_cur  = r_next;
      t_prev = t_cur;
      t_cur  = t_next;
    end
    if (t_prev < 0) t_prev = t_prev + longint'({2'b00, PRIME});
    return t_prev[W-1:0];
  endfunction

  function automatic rsp_t field_op_result(input req_t r);
    rsp_t         o;
    logic [W-1:0] a, b;
    a = fold_once(r.operand_a);
    b = fold_once(r.operand_b);
    o.result       = '0;
    o.zero_inverse = 1'b0;
    case (r.opcode)
      OP_ADD: o.result = field_add(a, b);
      OP_SUB: o.result = field_sub(a, b);
      OP_MUL: o.result = field_mul(a, b);
      default: begin
        if (a == '0) o.zero_inverse = 1'b1;
        else o.result = field_inv(a);
      end
    endcase
    return o;
  endfunction

  always @(posedge clk) begin : watch
    rsp_t want;
    int   errs;
    errs = 0;
    if (!rst) begin
      if (done) begin
        if (expected_rsp_q.size() == 0) begin
          $display("%0t: result beat with none expected: result %h zero_inverse %b",
                   $time, rsp.result, rsp.zero_inverse);
          errs++;
        end else begin
          want = expected_rsp_q.pop_front();
          if (rsp.result !== want.result) begin
            $display("%0t: result mismatch: expected %h actual %h",
                     $time, want.result, rsp.result);
            errs++;
          end
          if (rsp.zero_inverse !== want.zero_inverse) begin
            $display("%0t: zero_inverse mismatch: expected %b actual %b",
                     $time, want.zero_inverse, rsp.zero_inverse);
            errs++;
          end
        end
      end
      if (start && !busy) expected_rsp_q.push_back(field_op_result(req));
    end
    fail_cnt    <= fail_cnt + errs;
    pending_cnt <= expected_rsp_q.size();
  end

endmodule

FILE: tb/sv/tb_prime_field_alu.sv
`timescale 1ns / 1ps
module tb_prime_field_alu;
  import pfa_pkg::*;

  localparam int RANDOM_ITEMS = 1100;
  localparam int IDLE_LIMIT   = 4000;
  localparam logic [W-1:0] MAX62 = {W{1'b1}};

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  req_t req;
  logic done;
  rsp_t rsp;

  int mismatches;
  int outstanding;
  int idle_cycles = 0;
  int op_count[4];
  int zero_inv_reqs = 0;
  bit no_idle = 1'b0;

  logic [1:0] op_list[4] = '{OP_ADD, OP_SUB, OP_MUL, OP_INV};

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  prime_field_alu uut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .req   (req),
    .done  (done),
    .rsp   (rsp)
  );

  pfa_result_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .req         (req),
    .done        (done),
    .rsp         (rsp),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // end the run if neither channel moves for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no beat for %0d cycles", $time, IDLE_LIMIT);
        $display("FAIL");
        $finish;
      end
    end
  end

  function automatic logic [W-1:0] rand_word();
    logic [63:0] raw;
    raw = {$urandom(), $urandom()};
    return raw[W-1:0];
  endfunction

  function automatic logic [W-1:0] pick_operand();
    logic [W-1:0] span;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 6))
          0: return '0;
          1: return 62'd1;
          2: return 62'd2;
          3: return PRIME - 62'd1;
          4: return PRIME;
          5: return PRIME + 62'd1;
          default: return MAX62;
        endcase
      end
      1: begin
        // unreduced: somewhere in [PRIME, 2^62-1]
        span = MAX62 - PRIME + 62'd1;
        return PRIME + (rand_word() % span);
      end
      2: return W'($urandom_range(0, 255));
      default: return rand_word();
    endcase
  endfunction

  // present one command beat and hold it until taken
  task automatic send_cmd(input logic [1:0] op, input logic [W-1:0] a,
                          input logic [W-1:0] b);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start         <= 1'b1;
    req.opcode    <= op;
    req.operand_a <= a;
    req.operand_b <= b;
    op_count[op]++;
    if (op == OP_INV && (a == '0 || a == PRIME)) zero_inv_reqs++;
    do @(posedge clk); while (busy);
  endtask

  initial begin
    int i;
    for (i = 0; i < 4; i++) op_count[i] = 0;
    rst   <= 1'b1;
    start <= 1'b0;
    req   <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed corners
    send_cmd(OP_ADD, PRIME - 62'd1, PRIME - 62'd1);
    send_cmd(OP_ADD, '0, '0);
    send_cmd(OP_ADD, PRIME - 62'd1, 62'd1);
    send_cmd(OP_ADD, MAX62, MAX62);
    send_cmd(OP_SUB, '0, PRIME - 62'd1);
    send_cmd(OP_SUB, PRIME - 62'd1, '0);
    send_cmd(OP_SUB, 62'd5, 62'd5);
    send_cmd(OP_SUB, PRIME, 62'd1);
    send_cmd(OP_SUB, MAX62, PRIME + 62'd1);
    send_cmd(OP_MUL, PRIME - 62'd1, PRIME - 62'd1);
    send_cmd(OP_MUL, '0, PRIME - 62'd1);
    send_cmd(OP_MUL, 62'd1, rand_word());
    send_cmd(OP_MUL, MAX62, PRIME + 62'd1);
    send_cmd(OP_MUL, MAX62, MAX62);
    send_cmd(OP_MUL, rand_word(), rand_word());
    send_cmd(OP_INV, '0, rand_word());
    send_cmd(OP_INV, PRIME, MAX62);
    send_cmd(OP_INV, 62'd1, '0);
    send_cmd(OP_INV, 62'd2, rand_word());
    send_cmd(OP_INV, PRIME - 62'd1, rand_word());
    send_cmd(OP_INV, MAX62, '0);
    send_cmd(OP_INV, 62'h2AAA_AAAA_AAAA_AAAA, '0);
    send_cmd(OP_INV, 62'h2AAA_AAAA_AAAA_AAAA, MAX62);
    send_cmd(OP_INV, 62'h0000_0000_8000_0000, rand_word());

    // random traffic, with every third stretch run back to back
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      no_idle = ((i / 64) % 3) == 2;
      send_cmd(op_list[$urandom_range(0, 3)], pick_operand(), pick_operand());
    end
    start <= 1'b0;

    do @(posedge clk); while (outstanding != 0);
    repeat (8) @(posedge clk);

    $display("Ran %0d commands: add %0d, sub %0d, mul %0d, inv %0d",
             op_count[0] + op_count[1] + op_count[2] + op_count[3],
             op_count[OP_ADD], op_count[OP_SUB], op_count[OP_MUL], op_count[OP_INV]);
    $display("Inverse-of-zero requests: %0d, mismatches: %0d", zero_inv_reqs, mismatches);
    if (mismatches == 0 && outstanding == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
